FILE: rtl/bmhpq_pkg.sv
// Shared types, constants and controller/datapath interface structs for the min-heap queue.
package bmhpq_pkg;

  localparam int DEPTH   = 1024;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CFG_W   = 11;
  localparam int VTX_W   = 16;
  localparam int KEY_W   = 32;
  localparam int ENTRY_W = VTX_W + KEY_W;
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CHILD_W = IDX_W + 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [VTX_W-1:0] vtx;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_EXT_L,
    S_EXT_R,
    S_EXT_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic ins_load;
    logic refuse_full;
    logic refuse_empty;
    logic rd_parent;
    logic wr_mov;
    logic wr_up;
    logic rd_root;
    logic take_root;
    logic take_last;
    logic rd_left;
    logic take_left;
    logic wr_down;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_ext;
    logic full;
    logic empty;
    logic i_zero;
    logic parent_le;
    logic l_ok;
    logic down_stop;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/bmhpq_req_if.sv
// Request channel: valid/ready handshake with insert/extract payload.
interface bmhpq_req_if import bmhpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [VTX_W-1:0]        vertex;
  logic signed [KEY_W-1:0] priority_req;

  modport source (output valid, req_type, vertex, priority_req, input ready);
  modport sink   (input valid, req_type, vertex, priority_req, output ready);
endinterface

FILE: rtl/bmhpq_rsp_if.sv
// Response channel: valid/ready handshake with status, extracted entry and count.
interface bmhpq_rsp_if import bmhpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [VTX_W-1:0]        out_vertex;
  logic signed [KEY_W-1:0] out_priority;
  logic                    now_empty;
  logic [CNT_W-1:0]        entry_total;

  modport source (output valid, status, out_vertex, out_priority, now_empty, entry_total,
                  input ready);
  modport sink   (input valid, status, out_vertex, out_priority, now_empty, entry_total,
                  output ready);
endinterface

FILE: rtl/bmhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bmhpq_ctrl.sv
// Controller state machine sequencing sift-up and sift-down steps.
module bmhpq_ctrl import bmhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.is_ext) begin
            state_d = sts_i.empty ? S_RESP : S_EXT_ROOT;
          end else begin
            state_d = sts_i.full ? S_RESP : S_INS_RD;
          end
        end
      end
      S_INS_RD:   state_d = sts_i.i_zero ? S_RESP : S_INS_CMP;
      S_INS_CMP:  state_d = sts_i.parent_le ? S_RESP : S_INS_RD;
      S_EXT_ROOT: state_d = S_EXT_LAST;
      S_EXT_LAST: state_d = sts_i.cnt_zero ? S_RESP : S_EXT_L;
      S_EXT_L:    state_d = sts_i.l_ok ? S_EXT_R : S_RESP;
      S_EXT_R:    state_d = S_EXT_CMP;
      S_EXT_CMP:  state_d = sts_i.down_stop ? S_RESP : S_EXT_L;
      S_RESP:     state_d = sts_i.out_free ? S_IDLE : S_RESP;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          if (sts_i.is_ext) begin
            cmd_o.refuse_empty = sts_i.empty;
            cmd_o.rd_root      = !sts_i.empty;
          end else begin
            cmd_o.refuse_full = sts_i.full;
            cmd_o.ins_load    = !sts_i.full;
          end
        end
      end
      S_INS_RD: begin
        cmd_o.wr_mov    = sts_i.i_zero;
        cmd_o.rd_parent = !sts_i.i_zero;
      end
      S_INS_CMP: begin
        cmd_o.wr_mov = sts_i.parent_le;
        cmd_o.wr_up  = !sts_i.parent_le;
      end
      S_EXT_ROOT: cmd_o.take_root = 1'b1;
      S_EXT_LAST: cmd_o.take_last = 1'b1;
      S_EXT_L: begin
        cmd_o.rd_left = sts_i.l_ok;
        cmd_o.wr_mov  = !sts_i.l_ok;
      end
      S_EXT_R: cmd_o.take_left = 1'b1;
      S_EXT_CMP: begin
        cmd_o.wr_mov  = sts_i.down_stop;
        cmd_o.wr_down = !sts_i.down_stop;
      end
      S_RESP:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/bmhpq_dp.sv
// Datapath: heap storage, moving entry, count, limit register and response register.
module bmhpq_dp import bmhpq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    req_type_i,
  input  logic [VTX_W-1:0]        vertex_i,
  input  logic signed [KEY_W-1:0] priority_req_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [1:0]              status_o,
  output logic [VTX_W-1:0]        out_vertex_o,
  output logic signed [KEY_W-1:0] out_priority_o,
  output logic                    now_empty_o,
  output logic [CNT_W-1:0]        entry_total_o
);

  logic [CFG_W-1:0]   cap_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   i_q;
  entry_t             mov_q, best_q, res_q;
  status_e            res_status_q;
  logic               best_l_q, r_ok_q;
  logic [1:0]         out_status_q;
  entry_t             out_entry_q;
  logic               out_empty_q;
  logic [CNT_W-1:0]   out_total_q;

  entry_t             rd_data, wdata, chosen;
  logic               we, re;
  logic [IDX_W-1:0]   raddr, parent, s_idx;
  logic [CMP_W-1:0]   cap_x, depth_x, lim;
  logic [CHILD_W-1:0] l_w, r_w, cnt_x;
  logic               left_lt, right_lt;

  assign cap_x   = CMP_W'(cap_q);
  assign depth_x = CMP_W'(DEPTH);
  assign lim     = (cap_x > depth_x) ? depth_x : cap_x;
  assign parent  = (i_q - IDX_W'(1)) >> 1;
  assign l_w     = {1'b0, i_q, 1'b1};
  assign r_w     = l_w + CHILD_W'(1);
  assign cnt_x   = CHILD_W'(cnt_q);

  assign left_lt  = $signed(rd_data.key) < $signed(mov_q.key);
  assign right_lt = r_ok_q && ($signed(rd_data.key) < $signed(best_q.key));
  assign chosen   = right_lt ? rd_data : best_q;
  assign s_idx    = right_lt ? IDX_W'(r_w) : IDX_W'(l_w);

  always_comb begin
    raddr = '0;
    if (cmd_i.take_root) begin
      raddr = IDX_W'(cnt_q - CNT_W'(1));
    end else if (cmd_i.rd_parent) begin
      raddr = parent;
    end else if (cmd_i.rd_left) begin
      raddr = IDX_W'(l_w);
    end else if (cmd_i.take_left) begin
      raddr = IDX_W'(r_w);
    end
  end

  assign re    = cmd_i.rd_root | cmd_i.take_root | cmd_i.rd_parent | cmd_i.rd_left
               | cmd_i.take_left;
  assign we    = cmd_i.wr_mov | cmd_i.wr_up | cmd_i.wr_down;
  assign wdata = cmd_i.wr_mov ? mov_q : (cmd_i.wr_up ? rd_data : chosen);

  bmhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (i_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CFG_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.ins_load) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.take_root) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_load) begin
      mov_q        <= {vertex_i, priority_req_i};
      i_q          <= IDX_W'(cnt_q);
      res_q        <= '0;
      res_status_q <= ST_DONE;
    end
    if (cmd_i.refuse_full) begin
      res_q        <= '0;
      res_status_q <= ST_FULL;
    end
    if (cmd_i.refuse_empty) begin
      res_q        <= '0;
      res_status_q <= ST_EMPTY;
    end
    if (cmd_i.take_root) begin
      res_q        <= rd_data;
      res_status_q <= ST_DONE;
    end
    if (cmd_i.take_last) begin
      mov_q <= rd_data;
      i_q   <= '0;
    end
    if (cmd_i.wr_up) begin
      i_q <= parent;
    end
    if (cmd_i.wr_down) begin
      i_q <= s_idx;
    end
    if (cmd_i.take_left) begin
      best_q   <= left_lt ? rd_data : mov_q;
      best_l_q <= left_lt;
      r_ok_q   <= r_w < cnt_x;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_entry_q  <= res_q;
      out_empty_q  <= (cnt_q == '0);
      out_total_q  <= cnt_q;
    end
  end

  assign sts_o.is_ext    = (req_type_i == REQ_EXTRACT);
  assign sts_o.full      = CMP_W'(cnt_q) >= lim;
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.i_zero    = (i_q == '0);
  assign sts_o.parent_le = $signed(rd_data.key) <= $signed(mov_q.key);
  assign sts_o.l_ok      = l_w < cnt_x;
  assign sts_o.down_stop = !right_lt && !best_l_q;
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_vertex_o   = out_entry_q.vtx;
  assign out_priority_o = out_entry_q.key;
  assign now_empty_o    = out_empty_q;
  assign entry_total_o  = out_total_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above storage depth");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_load |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("insert did not advance entry count");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> CHILD_W'(i_q) < cnt_x)
    else $error("heap write beyond entry count");

endmodule

FILE: rtl/binary_min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue.
//
//   channel  | direction | handshake        | payload
//   req_i    | in        | valid/ready      | req_type, vertex, priority_req
//   rsp_o    | out       | valid/ready      | status, out_vertex, out_priority,
//            |           |                  | now_empty, entry_total
//   cfg      | in        | cfg_we_i         | cfg_wdata_i (capacity limit)
//
// One request at a time; the single read port of the heap RAM sets the pace.
// Insert: sifts up a level at a time (read parent, compare) until the root or a parent not larger.
// Extract: reads root and last entry, then sifts down a level at a time (read left, right, compare)
// until no child is smaller; an extract that leaves the heap empty skips this. Refused: heap untouched.
// Reset clears the count and sets the limit to 1024; no clearing pass.
// A stalled response holds in its register; the next request is taken meanwhile.
module binary_min_heap_priority_queue import bmhpq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bmhpq_req_if.sink        req_i,
  bmhpq_rsp_if.source      rsp_o
);

  cmd_t cmd;
  sts_t sts;

  bmhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmhpq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_i.req_type),
    .vertex_i       (req_i.vertex),
    .priority_req_i (req_i.priority_req),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .out_vertex_o   (rsp_o.out_vertex),
    .out_priority_o (rsp_o.out_priority),
    .now_empty_o    (rsp_o.now_empty),
    .entry_total_o  (rsp_o.entry_total)
  );

  assign req_i.ready = cmd.in_ready;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 1ps

module tb;
  import bmhpq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [VTX_W-1:0]        vtx;
    logic signed [KEY_W-1:0] key;
  } node_t;

  typedef struct packed {
    req_e                    kind;
    logic [VTX_W-1:0]        vtx;
    logic signed [KEY_W-1:0] key;
  } heap_req_t;

  typedef struct packed {
    status_e                 status;
    logic [VTX_W-1:0]        vtx;
    logic signed [KEY_W-1:0] key;
    logic                    empty;
    logic [CNT_W-1:0]        total;
  } heap_rsp_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  bmhpq_req_if req_bus ();
  bmhpq_rsp_if rsp_bus ();

  binary_min_heap_priority_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  node_t       heap_mdl [DEPTH];
  int unsigned mdl_count;
  int unsigned mdl_limit;

  heap_req_t req_backlog[$];
  heap_rsp_t expected_rsps[$];
  heap_req_t req_now;
  logic      no_idle;
  int        err_count;
  int        cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 200) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic heap_rsp_t heap_apply(input heap_req_t rq);
    heap_rsp_t   r;
    int unsigned cap, i, p, l, rt, s;
    node_t       t;
    logic        done;
    r = '0;
    r.status = ST_DONE;
    cap = (mdl_limit > DEPTH) ? DEPTH : mdl_limit;
    if (rq.kind == REQ_INSERT) begin
      if (mdl_count >= cap) begin
        r.status = ST_FULL;
      end else begin
        i = mdl_count;
        heap_mdl[i].vtx = rq.vtx;
        heap_mdl[i].key = rq.key;
        mdl_count++;
        done = 1'b0;
        while (i > 0 && !done) begin
          p = (i - 1) / 2;
          if (heap_mdl[p].key <= heap_mdl[i].key) begin
            done = 1'b1;
          end else begin
            t = heap_mdl[p];
            heap_mdl[p] = heap_mdl[i];
            heap_mdl[i] = t;
            i = p;
          end
        end
      end
    end else begin
      if (mdl_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.vtx = heap_mdl[0].vtx;
        r.key = heap_mdl[0].key;
        heap_mdl[0] = heap_mdl[mdl_count - 1];
        mdl_count--;
        i = 0;
        done = 1'b0;
        while (!done) begin
          l = 2 * i + 1;
          rt = 2 * i + 2;
          s = i;
          if (l < mdl_count && heap_mdl[l].key < heap_mdl[s].key) s = l;
          if (rt < mdl_count && heap_mdl[rt].key < heap_mdl[s].key) s = rt;
          if (s == i) begin
            done = 1'b1;
          end else begin
            t = heap_mdl[i];
            heap_mdl[i] = heap_mdl[s];
            heap_mdl[s] = t;
            i = s;
          end
        end
      end
    end
    r.empty = (mdl_count == 0);
    r.total = CNT_W'(mdl_count);
    return r;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.req_type <= 1'b0;
      req_bus.vertex <= '0;
      req_bus.priority_req <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) expected_rsps.push_back(heap_apply(req_now));
      if (!req_bus.valid || req_bus.ready) begin
        if (req_backlog.size() > 0 && (no_idle || $urandom_range(0, 99) >= 23)) begin
          req_now = req_backlog.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.req_type <= req_now.kind;
          req_bus.vertex <= req_now.vtx;
          req_bus.priority_req <= req_now.key;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    heap_rsp_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsps.size() == 0) begin
          note_error("response with no request pending");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_bus.status !== want.status)
            note_error($sformatf("status got %0d want %0d", rsp_bus.status, want.status));
          if (rsp_bus.out_vertex !== want.vtx)
            note_error($sformatf("out_vertex got %0h want %0h", rsp_bus.out_vertex, want.vtx));
          if (rsp_bus.out_priority !== want.key)
            note_error($sformatf("out_priority got %0d want %0d",
                                 rsp_bus.out_priority, want.key));
          if (rsp_bus.now_empty !== want.empty)
            note_error($sformatf("now_empty got %0b want %0b", rsp_bus.now_empty, want.empty));
          if (rsp_bus.entry_total !== want.total)
            note_error($sformatf("entry_total got %0d want %0d",
                                 rsp_bus.entry_total, want.total));
        end
      end
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_req(input req_e kind, input int unsigned vtx, input int key);
    heap_req_t rq;
    rq.kind = kind;
    rq.vtx = VTX_W'(vtx);
    rq.key = key;
    req_backlog.push_back(rq);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || req_bus.valid || expected_rsps.size() != 0);
  endtask

  task automatic set_capacity(input int unsigned value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_limit = value & 32'h7FF;
  endtask

  function automatic int pick_key();
    int k;
    case ($urandom_range(0, 3))
      0: k = $urandom;
      1: k = int'($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: k = 32'h8000_0000;
          1: k = 32'h7FFF_FFFF;
          2: k = 0;
          default: k = -1;
        endcase
      end
      default: k = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return k;
  endfunction

  task automatic queue_random(input int n, input int insert_pct);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < insert_pct)
        push_req(REQ_INSERT, $urandom_range(0, 65535), pick_key());
      else
        push_req(REQ_EXTRACT, $urandom_range(0, 65535), $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    mdl_count = 0;
    mdl_limit = CFG_RESET;
    err_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_req(REQ_EXTRACT, 0, 0);
    push_req(REQ_INSERT, 0, 32'h8000_0000);
    push_req(REQ_INSERT, 16'hFFFF, 32'h7FFF_FFFF);
    push_req(REQ_INSERT, 16'h1234, 5);
    push_req(REQ_INSERT, 16'h1235, 5);
    push_req(REQ_INSERT, 16'h1236, 5);
    push_req(REQ_INSERT, 16'hAAAA, -1);
    push_req(REQ_INSERT, 16'h5555, 0);
    repeat (8) push_req(REQ_EXTRACT, 16'hFFFF, -1);

    set_capacity(0);
    push_req(REQ_INSERT, 16'h0F0F, 7);
    push_req(REQ_EXTRACT, 0, 0);

    set_capacity(2);
    push_req(REQ_INSERT, 16'h0001, 9);
    push_req(REQ_INSERT, 16'h0002, -9);
    push_req(REQ_INSERT, 16'h0003, 0);

    set_capacity(2047);
    push_req(REQ_INSERT, 16'h0004, 9);

    // hold the count above a lowered limit
    set_capacity(1);
    push_req(REQ_INSERT, 16'h0005, 1);
    repeat (3) push_req(REQ_EXTRACT, 0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_capacity(2047);
        1: set_capacity(3);
        2: set_capacity($urandom_range(4, 40));
        3: set_capacity(1);
        4: set_capacity(1024);
        5: set_capacity($urandom_range(0, 2047));
        6: set_capacity(5);
        default: set_capacity(2047);
      endcase
      if (ph == 4) begin
        no_idle = 1'b1;
        queue_random(150, 90);
        queue_random(90, 15);
        wait_drained();
        no_idle = 1'b0;
      end else if (ph == 7) begin
        queue_random(50, 55);
        wait_drained();
        queue_random(50, 40);
      end else begin
        queue_random(100, (ph % 2 == 0) ? 60 : 45);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
